[src/assert_macros.svh]
// Assertion macros for the checker module pnc_checker.
// Each macro samples on the rising edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An implication that is checked in the same cycle.
`define CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// An implication that is checked in the following cycle.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pnc_pkg.sv]
`timescale 1ns / 1ps

package pnc_pkg;

  // Width of the number field on the input port.
  localparam int unsigned IN_BITS  = 16;
  // Width of the divisor sum on the output port, and its saturation value.
  localparam int unsigned SUM_BITS = 18;
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT,
    S_DONE
  } pnc_state_t;

endpackage

[src/pnc_rem_unit.sv]
`timescale 1ns / 1ps

// Restoring remainder unit: one quotient bit per cycle.
module pnc_rem_unit #(
  parameter int unsigned W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] remainder
);

  localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic [W:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, dvd_r[W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // Bring down the next dividend bit and subtract the divisor when it fits.
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[W-1:0];
      end
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

[src/perfect_number_check.sv]
`timescale 1ns / 1ps

// Perfect number test by proper-divisor sum.
// The input channel (in_valid, in_ready, in_number) takes one number per request. The
// result channel (out_valid, out_ready, out_is_perfect, out_divisor_sum) returns one
// result per number: the sum of all divisors below the number, saturated at 262143,
// and a flag that is set when that sum equals the number. Numbers 0 and 1 give a sum of
// zero and are never perfect. Only the low NUMBER_BITS bits of the number are used.
// Every candidate from 1 to number-1 goes through one shared restoring remainder unit
// that produces one bit per cycle. The block works on one number at a time and holds
// in_ready low from acceptance until its result is in the output register; in_ready
// is high again in the same cycle as out_valid. The output register frees the
// sequencer, so the next number is taken while the previous result still waits. If
// the receiver stalls with a result unread when the next one is ready, the sequencer
// holds that finished result until out_ready.
// A synchronous reset (rst_n low) returns the sequencer to idle and drops out_valid.
module perfect_number_check #(
  parameter int unsigned NUMBER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pnc_pkg::IN_BITS-1:0]     in_number,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_is_perfect,
  output logic [pnc_pkg::SUM_BITS-1:0]    out_divisor_sum
);

  import pnc_pkg::*;

  localparam int unsigned W  = NUMBER_BITS;
  // Adder width: wide enough for the sum plus any candidate, with a carry.
  localparam int unsigned AW = ((W > SUM_BITS) ? W : SUM_BITS) + 1;

  pnc_state_t          state_r, state_nxt;
  logic [W-1:0]        held_r, held_nxt;
  logic [W-1:0]        cand_r, cand_nxt;
  logic [SUM_BITS-1:0] sum_r, sum_nxt;
  logic                ovf_r, ovf_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic                operf_r, operf_nxt;
  logic [SUM_BITS-1:0] osum_r, osum_nxt;

  logic                div_start;
  logic                div_done;
  logic [W-1:0]        div_rem;
  logic [W-1:0]        n_in;
  logic [AW-1:0]       sum_add;
  logic                accept;
  logic                out_free;

  // A size cast keeps exactly the low NUMBER_BITS bits of the number.
  assign n_in     = W'(in_number);
  assign accept   = in_valid && in_ready;
  assign out_free = !ovalid_r || out_ready;
  assign sum_add  = AW'(sum_r) + AW'(cand_r);

  pnc_rem_unit #(
    .W(W)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (held_r),
    .divisor   (cand_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    cand_nxt   = cand_r;
    sum_nxt    = sum_r;
    ovf_nxt    = ovf_r;
    ovalid_nxt = ovalid_r;
    operf_nxt  = operf_r;
    osum_nxt   = osum_r;
    div_start  = 1'b0;
    in_ready   = (state_r == S_IDLE);

    // The receiver taking the current result frees the output register.
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          held_nxt = n_in;
          cand_nxt = W'(1);
          sum_nxt  = '0;
          ovf_nxt  = 1'b0;
          // Zero and one have no candidates at all.
          if (n_in < W'(2)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LAUNCH;
          end
        end
      end
      S_LAUNCH: begin
        div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          if (div_rem == '0) begin
            // Saturating accumulation; the overflow flag keeps a clipped sum from
            // ever matching the number.
            if (sum_add > AW'(SUM_MAX)) begin
              sum_nxt = SUM_MAX;
              ovf_nxt = 1'b1;
            end else begin
              sum_nxt = sum_add[SUM_BITS-1:0];
            end
          end
          if (cand_r == held_r - W'(1)) begin
            state_nxt = S_DONE;
          end else begin
            cand_nxt  = cand_r + W'(1);
            state_nxt = S_LAUNCH;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          osum_nxt   = sum_r;
          operf_nxt  = !ovf_r && (held_r != '0) && (AW'(sum_r) == AW'(held_r));
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r  <= held_nxt;
    cand_r  <= cand_nxt;
    sum_r   <= sum_nxt;
    ovf_r   <= ovf_nxt;
    operf_r <= operf_nxt;
    osum_r  <= osum_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_is_perfect  = operf_r;
  assign out_divisor_sum = osum_r;

endmodule

[src/pnc_checker.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pnc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_is_perfect,
  input logic [pnc_pkg::SUM_BITS-1:0] out_divisor_sum
);

  import pnc_pkg::*;

  // A pending result is held until the receiver takes it.
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // Only one number is in work at a time.
  `CHK_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken while busy")

  // No result can appear in the cycle straight after a request is taken.
  `CHK_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid),
            "result appeared too early")

  // The smallest perfect number is six, so a perfect flag needs at least that sum.
  `CHK_SAME(a_perfect_sum, out_valid && out_is_perfect,
            out_divisor_sum >= SUM_BITS'(6), "perfect flag with too small a sum")

endmodule

bind perfect_number_check pnc_checker u_pnc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_is_perfect  (out_is_perfect),
  .out_divisor_sum (out_divisor_sum)
);

[bench/divisor_sum_checker.sv]
`timescale 1ns / 1ps

module divisor_sum_checker #(
  parameter int unsigned NUMBER_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [pnc_pkg::IN_BITS-1:0]   in_number,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_is_perfect,
  input  logic [pnc_pkg::SUM_BITS-1:0]  out_divisor_sum,
  output int                            mismatches,
  output int                            outstanding
);

  typedef struct packed {
    logic                         is_perfect;
    logic [pnc_pkg::SUM_BITS-1:0] divisor_sum;
  } sum_verdict_t;

  sum_verdict_t awaited_verdicts[$];

  // Proper divisors are gathered in pairs (d, n/d) up to the square root.
  function automatic sum_verdict_t judge_number(input logic [pnc_pkg::IN_BITS-1:0] raw);
    logic [63:0]  n;
    logic [63:0]  d;
    logic [63:0]  total;
    sum_verdict_t v;
    n = 64'(raw) & ((64'd1 << NUMBER_BITS) - 64'd1);
    total = 64'd0;
    if (n >= 64'd2) begin
      for (d = 64'd1; d * d <= n; d = d + 64'd1) begin
        if (n % d == 64'd0) begin
          if (d < n) total = total + d;
          if ((n / d) != d && (n / d) < n) total = total + n / d;
        end
      end
    end
    // The flag compares the full sum, so saturation can never fake a match.
    v.is_perfect = (n != 64'd0) && (total == n);
    v.divisor_sum = (total > 64'(pnc_pkg::SUM_MAX)) ? pnc_pkg::SUM_MAX
                                                     : total[pnc_pkg::SUM_BITS-1:0];
    return v;
  endfunction

  always @(posedge clk) begin
    sum_verdict_t want;
    if (!rst_n) begin
      awaited_verdicts.delete();
      mismatches = 0;
    end else begin
      if (in_valid && in_ready) awaited_verdicts.push_back(judge_number(in_number));
      if (out_valid && out_ready) begin
        if (awaited_verdicts.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result is_perfect=%0b divisor_sum=%0d",
                   $time, out_is_perfect, out_divisor_sum);
        end else begin
          want = awaited_verdicts.pop_front();
          if (out_is_perfect !== want.is_perfect) begin
            mismatches++;
            $display("%0t: is_perfect expected %0b actual %0b",
                     $time, want.is_perfect, out_is_perfect);
          end
          if (out_divisor_sum !== want.divisor_sum) begin
            mismatches++;
            $display("%0t: divisor_sum expected %0d actual %0d",
                     $time, want.divisor_sum, out_divisor_sum);
          end
        end
      end
    end
    outstanding <= awaited_verdicts.size();
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NUMBER_BITS       = 16;
  // Number of random requests offered after the directed part.
  localparam int unsigned RANDOM_REQUESTS   = 85;
  // Length of the long receiver hold-off that fills the block up.
  localparam int unsigned LONG_STALL_CYCLES = 600;
  // Small requests offered while that hold-off is in force.
  localparam int unsigned BURST_REQUESTS    = 12;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [pnc_pkg::IN_BITS-1:0]   in_number;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_is_perfect;
  logic [pnc_pkg::SUM_BITS-1:0]  out_divisor_sum;

  // Percentages of cycles in which the sender and the receiver sit idle.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // Raised by the stimulus to ask the receiver for one long hold-off.
  logic        long_stall_req;
  // Set by the receiver once that hold-off has been served.
  logic        long_stall_done;
  int          mismatches;
  int          outstanding;

  // Directed numbers: zero and one (no candidates at all), the smallest primes,
  // the perfect numbers that fit in sixteen bits, a square, an amicable number,
  // the smallest odd abundant number and the all-ones number, which is also the
  // slowest request the block can be given.
  logic [pnc_pkg::IN_BITS-1:0] directed_numbers[] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd28, 16'd496, 16'd8128,
    16'd12, 16'd25, 16'd97, 16'd220, 16'd945, 16'hFFFF
  };

  always #5 clk = ~clk;

  perfect_number_check #(
    .NUMBER_BITS(NUMBER_BITS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_number      (in_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_perfect (out_is_perfect),
    .out_divisor_sum(out_divisor_sum)
  );

  divisor_sum_checker #(
    .NUMBER_BITS(NUMBER_BITS)
  ) checker_inst (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_number      (in_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_perfect (out_is_perfect),
    .out_divisor_sum(out_divisor_sum),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // The block tries every candidate below the number, so random numbers are
  // kept mostly small. A share of perfect numbers makes sure the flag is
  // seen set often enough.
  function automatic logic [pnc_pkg::IN_BITS-1:0] pick_number();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80) return pnc_pkg::IN_BITS'($urandom_range(255, 1));
    if (roll < 92) return pnc_pkg::IN_BITS'($urandom_range(1023, 256));
    case ($urandom_range(2))
      0:       return 16'd6;
      1:       return 16'd28;
      default: return 16'd496;
    endcase
  endfunction

  // Offers one request and returns at the edge where it is accepted. Valid is
  // only dropped when an idle gap is wanted, so back-to-back requests keep it
  // high without a second assignment in the same step.
  task automatic offer_number(input logic [pnc_pkg::IN_BITS-1:0] number);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= number;
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver. It stalls at random according to recv_idle_pct, and on request
  // holds out_ready low for a long stretch that it counts itself.
  initial begin
    out_ready       = 1'b0;
    long_stall_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (long_stall_req && !long_stall_done) begin
        out_ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
        long_stall_done <= 1'b1;
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_number      = '0;
    long_stall_req = 1'b0;
    send_idle_pct  = 7;
    recv_idle_pct  = 79;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, under the first idling pattern.
    foreach (directed_numbers[i]) offer_number(directed_numbers[i]);

    // First third of the random part: a sender that rarely idles and a
    // receiver that mostly stalls.
    repeat (RANDOM_REQUESTS / 3) offer_number(pick_number());

    // Second third: the other way round.
    send_idle_pct = 79;
    recv_idle_pct = 7;
    repeat (RANDOM_REQUESTS / 3) offer_number(pick_number());

    // Last third: nobody idles. It opens with a long receiver hold-off while
    // a burst of cheap requests keeps coming, so that the output register and
    // the sequencer both fill and in_ready is held low.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_stall_req <= 1'b1;
    repeat (BURST_REQUESTS) offer_number(pnc_pkg::IN_BITS'($urandom_range(12, 1)));
    repeat (RANDOM_REQUESTS - 2 * (RANDOM_REQUESTS / 3) - BURST_REQUESTS)
      offer_number(pick_number());
    in_valid <= 1'b0;

    // Let every outstanding request drain, then allow a short tail in which
    // any surplus result would still be caught by the checker.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog. The all-ones number alone has the most candidates of any request, so
  // the bound is set several times above a full correct run.
  initial begin
    #80_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
